[rtl/core/aesp_pkg.sv]
// shared types, byte codes and sizes for the escape sequence parser
package aesp_pkg;

  localparam int MAX_PARAMS_DEF        = 16;
  localparam int MAX_INTERMEDIATES_DEF = 4;
  localparam int MAX_OSC_BYTES_DEF     = 64;

  localparam int ELEM_W  = 6;
  localparam int RUN_W   = 7;
  localparam int VALUE_W = 20;

  localparam logic [4:0] ENABLE_RESET = 5'd31;

  localparam logic [7:0] CH_BEL     = 8'h07;
  localparam logic [7:0] CH_CAN     = 8'h18;
  localparam logic [7:0] CH_SUB     = 8'h1A;
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] C0_MAX     = 8'h1F;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] INTER_MAX  = 8'h2F;
  localparam logic [7:0] DIGIT_MIN  = 8'h30;
  localparam logic [7:0] DIGIT_MAX  = 8'h39;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] PRIV_MIN   = 8'h3C;
  localparam logic [7:0] PRIV_MAX   = 8'h3F;
  localparam logic [7:0] FINAL_MIN  = 8'h40;
  localparam logic [7:0] CH_CSI     = 8'h5B;
  localparam logic [7:0] CH_OSC     = 8'h5D;
  localparam logic [7:0] FINAL_MAX  = 8'h7E;
  localparam logic [7:0] HIGH_MIN   = 8'h80;

  localparam logic [VALUE_W-1:0] VALUE_LIMIT = 20'd99999;

  typedef enum logic [2:0] {
    EV_EXECUTE = 3'd0,
    EV_PRINT   = 3'd1,
    EV_ESCAPE  = 3'd2,
    EV_CSI     = 3'd3,
    EV_OSC     = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [7:0]          code;
    logic [31:0]         packed_int;
    logic [2:0]          int_count;
    logic [4:0]          par_count;
    logic [VALUE_W-1:0]  par_value;
    logic [7:0]          osc_ch;
    logic [6:0]          osc_len;
    logic [ELEM_W-1:0]   idx;
    logic                last;
    logic                ovf;
  } evt_t;

  typedef struct packed {
    logic  wipe;
    logic  add_inter;
    logic  take_digit;
    logic  add_param;
    logic  clr_value;
    logic  clr_digit;
    logic  osc_clear;
    logic  osc_add;
    logic  latch_code;
    logic  emit;
    kind_t emit_kind;
    logic  issue;
    logic  run_osc;
  } cmd_t;

  typedef struct packed {
    logic [4:0] event_enable;
    logic       digit_seen;
    logic       issue_ok;
    logic       csi_last;
    logic       osc_last;
  } sts_t;

endpackage

[rtl/core/aesp_if.sv]
// channel interfaces: input bytes, result beats, enable register writes
interface aesp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface aesp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  code_byte;
  logic [31:0] packed_intermediates;
  logic [2:0]  intermediate_count;
  logic [4:0]  param_count;
  logic [19:0] param_value;
  logic [7:0]  osc_char;
  logic [6:0]  osc_length;
  logic [5:0]  element_index;
  logic        last_of_run;
  logic        overflow;

  modport source (
    output valid, input ready,
    output event_kind, output code_byte, output packed_intermediates,
    output intermediate_count, output param_count, output param_value,
    output osc_char, output osc_length, output element_index,
    output last_of_run, output overflow
  );
  modport sink (
    input valid, output ready,
    input event_kind, input code_byte, input packed_intermediates,
    input intermediate_count, input param_count, input param_value,
    input osc_char, input osc_length, input element_index,
    input last_of_run, input overflow
  );
endinterface

interface aesp_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] event_enable;

  modport source (output valid, output event_enable, input ready);
  modport sink   (input valid, input event_enable, output ready);
endinterface

[rtl/core/ansi_escape_sequence_parser.sv]
// top level of the terminal escape sequence parser
//
//   channel  dir  handshake     beat
//   bytes    in   valid/ready   one terminal byte (in_byte)
//   events   out  valid/ready   one result (kind, code, run fields)
//   cfg      in   valid/ready   event_enable write, always ready
//
// a csi dispatch emits max(1, param count) beats and an osc dispatch max(1, payload
// length) beats, one per cycle while the result queue has room, paced
// by the single store read port and the one-deep read stage
// results pass through a two-beat queue, so bytes keep flowing while one waits
// bytes.ready drops during a dispatch run or when read stage and queue already
// hold two beats and none leaves in that cycle
// synchronous reset; stores need no clearing pass
module ansi_escape_sequence_parser
  import aesp_pkg::*;
#(
  parameter int MAX_PARAMS        = MAX_PARAMS_DEF,
  parameter int MAX_INTERMEDIATES = MAX_INTERMEDIATES_DEF,
  parameter int MAX_OSC_BYTES     = MAX_OSC_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  aesp_in_if.sink     bytes,
  aesp_out_if.source  events,
  aesp_cfg_if.sink    cfg
);

  cmd_t cmd;
  sts_t sts;

  aesp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .sts   (sts),
    .cmd   (cmd)
  );

  aesp_dp #(
    .MAX_PARAMS        (MAX_PARAMS),
    .MAX_INTERMEDIATES (MAX_INTERMEDIATES),
    .MAX_OSC_BYTES     (MAX_OSC_BYTES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_byte (bytes.in_byte),
    .cmd     (cmd),
    .sts     (sts),
    .cfg     (cfg),
    .events  (events)
  );

endmodule

[rtl/core/aesp_ctrl.sv]
// parser state machine and dispatch run sequencer
module aesp_ctrl
  import aesp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  aesp_in_if.sink    bytes,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [7:0] {
    PS_GROUND     = 8'b0000_0001,
    PS_ESC        = 8'b0000_0010,
    PS_ESC_INT    = 8'b0000_0100,
    PS_CSI_ENTRY  = 8'b0000_1000,
    PS_CSI_PARAM  = 8'b0001_0000,
    PS_CSI_INT    = 8'b0010_0000,
    PS_CSI_IGNORE = 8'b0100_0000,
    PS_OSC        = 8'b1000_0000
  } pstate_t;

  typedef enum logic [2:0] {
    RUN_IDLE = 3'b001,
    RUN_CSI  = 3'b010,
    RUN_OSC  = 3'b100
  } rstate_t;

  pstate_t    ps;
  pstate_t    ps_next;
  rstate_t    run_st;
  rstate_t    run_next;
  logic [7:0] c;
  logic       accept;
  logic       ev_req;
  kind_t      ev_kind;
  logic       csi_go;
  logic       osc_go;

  assign c           = bytes.in_byte;
  assign bytes.ready = (run_st == RUN_IDLE) && sts.issue_ok;
  assign accept      = bytes.valid && bytes.ready;

  always_comb begin
    cmd      = '0;
    ps_next  = ps;
    run_next = run_st;
    ev_req   = 1'b0;
    ev_kind  = EV_EXECUTE;
    csi_go   = 1'b0;
    osc_go   = 1'b0;

    if (accept) begin
      if (c == CH_CAN || c == CH_SUB) begin
        ps_next = PS_GROUND;
        ev_req  = 1'b1;
      end else if (c == CH_ESC) begin
        cmd.wipe = 1'b1;
        ps_next  = PS_ESC;
      end else begin
        unique case (ps)
          PS_ESC: begin
            if (c <= C0_MAX) begin
              ev_req = 1'b1;
            end else if (c <= INTER_MAX) begin
              cmd.add_inter = 1'b1;
              ps_next       = PS_ESC_INT;
            end else if (c == CH_CSI) begin
              cmd.wipe = 1'b1;
              ps_next  = PS_CSI_ENTRY;
            end else if (c == CH_OSC) begin
              cmd.osc_clear = 1'b1;
              ps_next       = PS_OSC;
            end else if (c <= FINAL_MAX) begin
              ev_req  = 1'b1;
              ev_kind = EV_ESCAPE;
              ps_next = PS_GROUND;
            end else if (c >= HIGH_MIN) begin
              ev_req  = 1'b1;
              ev_kind = EV_PRINT;
              ps_next = PS_GROUND;
            end
          end
          PS_ESC_INT: begin
            if (c <= C0_MAX) begin
              ev_req = 1'b1;
            end else if (c <= INTER_MAX) begin
              cmd.add_inter = 1'b1;
            end else if (c <= FINAL_MAX) begin
              ev_req  = 1'b1;
              ev_kind = EV_ESCAPE;
              ps_next = PS_GROUND;
            end
          end
          PS_CSI_ENTRY: begin
            if (c <= C0_MAX) begin
              ev_req = 1'b1;
            end else if (c <= INTER_MAX) begin
              cmd.add_inter = 1'b1;
              ps_next       = PS_CSI_INT;
            end else if (c <= DIGIT_MAX) begin
              cmd.take_digit = 1'b1;
              ps_next        = PS_CSI_PARAM;
            end else if (c == CH_SEMI) begin
              ps_next = PS_CSI_PARAM;
            end else if (c >= PRIV_MIN && c <= PRIV_MAX) begin
              cmd.add_inter = 1'b1;
              ps_next       = PS_CSI_PARAM;
            end else if (c >= FINAL_MIN && c <= FINAL_MAX) begin
              csi_go = 1'b1;
            end
          end
          PS_CSI_PARAM: begin
            if (c <= C0_MAX) begin
              ev_req = 1'b1;
            end else if (c >= DIGIT_MIN && c <= DIGIT_MAX) begin
              cmd.take_digit = 1'b1;
            end else if (c == CH_SEMI) begin
              cmd.add_param = 1'b1;
              cmd.clr_value = 1'b1;
            end else if (c <= INTER_MAX) begin
              cmd.add_param = sts.digit_seen;
              cmd.clr_digit = 1'b1;
              cmd.add_inter = 1'b1;
              ps_next       = PS_CSI_INT;
            end else if (c >= FINAL_MIN && c <= FINAL_MAX) begin
              cmd.add_param = sts.digit_seen;
              csi_go        = 1'b1;
            end else if (c <= PRIV_MAX) begin
              ps_next = PS_CSI_IGNORE;
            end
          end
          PS_CSI_INT: begin
            if (c <= C0_MAX) begin
              ev_req = 1'b1;
            end else if (c <= INTER_MAX) begin
              cmd.add_inter = 1'b1;
            end else if (c <= PRIV_MAX) begin
              ps_next = PS_CSI_IGNORE;
            end else if (c <= FINAL_MAX) begin
              csi_go = 1'b1;
            end
          end
          PS_CSI_IGNORE: begin
            if (c <= C0_MAX) begin
              ev_req = 1'b1;
            end else if (c >= FINAL_MIN && c <= FINAL_MAX) begin
              ps_next = PS_GROUND;
            end
          end
          PS_OSC: begin
            if (c == CH_BEL) begin
              osc_go = 1'b1;
            end else if (c >= CH_SPACE) begin
              cmd.osc_add = 1'b1;
            end
          end
          default: begin
            ps_next = PS_GROUND;
            ev_req  = 1'b1;
            ev_kind = (c <= C0_MAX) ? EV_EXECUTE : EV_PRINT;
          end
        endcase
      end
    end

    if (csi_go) begin
      cmd.latch_code = 1'b1;
      ps_next        = PS_GROUND;
    end
    if (osc_go) begin
      ps_next = PS_GROUND;
    end

    cmd.emit      = ev_req && sts.event_enable[ev_kind];
    cmd.emit_kind = ev_kind;

    unique case (run_st)
      RUN_IDLE: begin
        if (csi_go && sts.event_enable[EV_CSI]) begin
          run_next = RUN_CSI;
        end else if (osc_go && sts.event_enable[EV_OSC]) begin
          run_next = RUN_OSC;
        end
      end
      RUN_CSI: begin
        cmd.issue = sts.issue_ok;
        if (sts.issue_ok && sts.csi_last) begin
          run_next = RUN_IDLE;
        end
      end
      RUN_OSC: begin
        cmd.issue   = sts.issue_ok;
        cmd.run_osc = 1'b1;
        if (sts.issue_ok && sts.osc_last) begin
          run_next = RUN_IDLE;
        end
      end
      default: run_next = RUN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ps     <= PS_GROUND;
      run_st <= RUN_IDLE;
    end else begin
      ps     <= ps_next;
      run_st <= run_next;
    end
  end

endmodule

[rtl/core/aesp_dp.sv]
// sequence stores, parameter accumulator, read stage and result queue
module aesp_dp
  import aesp_pkg::*;
#(
  parameter int MAX_PARAMS        = MAX_PARAMS_DEF,
  parameter int MAX_INTERMEDIATES = MAX_INTERMEDIATES_DEF,
  parameter int MAX_OSC_BYTES     = MAX_OSC_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  in_byte,
  input  cmd_t        cmd,
  output sts_t        sts,
  aesp_cfg_if.sink    cfg,
  aesp_out_if.source  events
);

  localparam int PCNT_W = $clog2(MAX_PARAMS + 1);
  localparam int PIDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int ICNT_W = $clog2(MAX_INTERMEDIATES + 1);
  localparam int IIDX_W = (MAX_INTERMEDIATES > 1) ? $clog2(MAX_INTERMEDIATES) : 1;
  localparam int OCNT_W = $clog2(MAX_OSC_BYTES + 1);
  localparam int OIDX_W = (MAX_OSC_BYTES > 1) ? $clog2(MAX_OSC_BYTES) : 1;

  logic [4:0]         enable;
  logic [VALUE_W-1:0] param_mem [MAX_PARAMS];
  logic [7:0]         osc_mem   [MAX_OSC_BYTES];
  logic [7:0]         inter     [MAX_INTERMEDIATES];
  logic [PCNT_W-1:0]  pcount;
  logic [ICNT_W-1:0]  icount;
  logic [OCNT_W-1:0]  olen;
  logic [VALUE_W-1:0] value;
  logic               digit_seen;
  logic               dropped;
  logic [7:0]         final_code;
  logic [ELEM_W-1:0]  elem;

  logic               pfull;
  logic               ifull;
  logic               ofull;
  logic [VALUE_W-1:0] param_wdata;
  logic [31:0]        packed_w;
  logic [RUN_W-1:0]   csi_len;
  logic [RUN_W-1:0]   osc_len;
  logic               csi_last;
  logic               osc_last;
  logic               last_now;

  logic               s1_valid;
  evt_t               s1;
  evt_t               s1_next;
  logic               s1_elem;
  logic               s1_elem_next;
  logic [VALUE_W-1:0] param_rd;
  logic [7:0]         osc_rd;
  evt_t               push_evt;

  evt_t               q [2];
  logic               q_head;
  logic [1:0]         q_count;
  logic               pop;
  logic [2:0]         occ;
  logic               issue_ok;

  // enable register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= ENABLE_RESET;
    end else if (cfg.valid) begin
      enable <= cfg.event_enable;
    end
  end

  assign pfull       = (pcount == PCNT_W'(MAX_PARAMS));
  assign ifull       = (icount == ICNT_W'(MAX_INTERMEDIATES));
  assign ofull       = (olen == OCNT_W'(MAX_OSC_BYTES));
  assign param_wdata = digit_seen ? value : '0;

  // sequence counters and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      pcount     <= '0;
      icount     <= '0;
      olen       <= '0;
      value      <= '0;
      digit_seen <= 1'b0;
      dropped    <= 1'b0;
    end else if (cmd.wipe) begin
      pcount     <= '0;
      icount     <= '0;
      value      <= '0;
      digit_seen <= 1'b0;
      dropped    <= 1'b0;
    end else if (cmd.osc_clear) begin
      olen    <= '0;
      dropped <= 1'b0;
    end else begin
      if (cmd.add_param && !pfull) begin
        pcount <= pcount + PCNT_W'(1);
      end
      if (cmd.add_inter && !ifull) begin
        icount <= icount + ICNT_W'(1);
      end
      if (cmd.osc_add && !ofull) begin
        olen <= olen + OCNT_W'(1);
      end
      if ((cmd.add_param && pfull) || (cmd.add_inter && ifull) || (cmd.osc_add && ofull)) begin
        dropped <= 1'b1;
      end
      if (cmd.take_digit) begin
        if (value <= VALUE_LIMIT) begin
          value <= (value << 3) + (value << 1) + VALUE_W'(in_byte[3:0]);
        end
        digit_seen <= 1'b1;
      end else if (cmd.clr_value) begin
        value      <= '0;
        digit_seen <= 1'b0;
      end else if (cmd.clr_digit) begin
        digit_seen <= 1'b0;
      end
    end
  end

  // stores
  always_ff @(posedge clk) begin
    if (cmd.add_param && !pfull) begin
      param_mem[pcount[PIDX_W-1:0]] <= param_wdata;
    end
    if (cmd.issue) begin
      param_rd <= param_mem[elem[PIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.osc_add && !ofull) begin
      osc_mem[olen[OIDX_W-1:0]] <= in_byte;
    end
    if (cmd.issue) begin
      osc_rd <= osc_mem[elem[OIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_inter && !ifull) begin
      inter[icount[IIDX_W-1:0]] <= in_byte;
    end
    if (cmd.latch_code) begin
      final_code <= in_byte;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_pack
    if (g < MAX_INTERMEDIATES) begin : g_used
      assign packed_w[8*g +: 8] = (ICNT_W'(g) < icount) ? inter[g] : 8'h00;
    end else begin : g_none
      assign packed_w[8*g +: 8] = 8'h00;
    end
  end

  // run element counter
  assign csi_len  = (pcount == '0) ? RUN_W'(1) : RUN_W'(pcount);
  assign osc_len  = (olen == '0) ? RUN_W'(1) : RUN_W'(olen);
  assign csi_last = (RUN_W'(elem) == csi_len - RUN_W'(1));
  assign osc_last = (RUN_W'(elem) == osc_len - RUN_W'(1));
  assign last_now = cmd.run_osc ? osc_last : csi_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      elem <= '0;
    end else if (cmd.issue) begin
      elem <= last_now ? '0 : elem + ELEM_W'(1);
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.emit || cmd.issue;
    end
  end

  always_comb begin
    s1_next      = '0;
    s1_elem_next = 1'b0;
    if (cmd.emit) begin
      s1_next.kind = cmd.emit_kind;
      s1_next.code = in_byte;
      s1_next.last = 1'b1;
      if (cmd.emit_kind == EV_ESCAPE) begin
        s1_next.packed_int = packed_w;
        s1_next.int_count  = 3'(icount);
        s1_next.ovf        = dropped;
      end
    end else begin
      s1_next.idx  = elem;
      s1_next.last = last_now;
      s1_next.ovf  = dropped;
      if (cmd.run_osc) begin
        s1_next.kind    = EV_OSC;
        s1_next.code    = CH_BEL;
        s1_next.osc_len = 7'(olen);
        s1_elem_next    = (RUN_W'(elem) < RUN_W'(olen));
      end else begin
        s1_next.kind       = EV_CSI;
        s1_next.code       = final_code;
        s1_next.packed_int = packed_w;
        s1_next.int_count  = 3'(icount);
        s1_next.par_count  = 5'(pcount);
        s1_elem_next       = (RUN_W'(elem) < RUN_W'(pcount));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit || cmd.issue) begin
      s1      <= s1_next;
      s1_elem <= s1_elem_next;
    end
  end

  always_comb begin
    push_evt           = s1;
    push_evt.par_value = (s1.kind == EV_CSI && s1_elem) ? param_rd : '0;
    push_evt.osc_ch    = (s1.kind == EV_OSC && s1_elem) ? osc_rd : 8'h00;
  end

  // two-beat result queue
  assign pop      = events.valid && events.ready;
  assign occ      = {1'b0, q_count} + {2'b00, s1_valid};
  assign issue_ok = pop ? (occ < 3'd3) : (occ < 3'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
      q_head  <= 1'b0;
    end else begin
      q_count <= q_count + {1'b0, s1_valid} - {1'b0, pop};
      if (pop) begin
        q_head <= ~q_head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      q[q_head ^ q_count[0]] <= push_evt;
    end
  end

  assign events.valid                = (q_count != 2'd0);
  assign events.event_kind           = q[q_head].kind;
  assign events.code_byte            = q[q_head].code;
  assign events.packed_intermediates = q[q_head].packed_int;
  assign events.intermediate_count   = q[q_head].int_count;
  assign events.param_count          = q[q_head].par_count;
  assign events.param_value          = q[q_head].par_value;
  assign events.osc_char             = q[q_head].osc_ch;
  assign events.osc_length           = q[q_head].osc_len;
  assign events.element_index        = q[q_head].idx;
  assign events.last_of_run          = q[q_head].last;
  assign events.overflow             = q[q_head].ovf;

  assign sts.event_enable = enable;
  assign sts.digit_seen   = digit_seen;
  assign sts.issue_ok     = issue_ok;
  assign sts.csi_last     = csi_last;
  assign sts.osc_last     = osc_last;

endmodule
